// ===== src/vbd_pkg.sv =====
// vbd_pkg: shared types and constants of the bearing CORDIC pipeline.
// Used by vbd_front, vbd_cell, vbd_back and vector_bearing_degrees.
// No dependencies.
package vbd_pkg;

  localparam int ANG_FRAC  = 20;  // fraction bits of the angle
  localparam int XY_SCALE  = 32;  // fraction bits of x and y in the cells
  localparam int XY_GUARD  = 3;   // gain and sign headroom of x and y
  localparam int TABLE_LEN = 32;
  localparam int AW        = 28;  // width of one arctangent entry
  localparam int ZW        = 29;  // signed angle accumulator
  localparam int DEG_W     = 8;   // whole degrees 0..180
  localparam int BW        = 9;   // bearing 0..359

  localparam logic [ZW-1:0] Z45  = ZW'(45)  << ANG_FRAC;
  localparam logic [ZW-1:0] Z90  = ZW'(90)  << ANG_FRAC;
  localparam logic [ZW-1:0] Z180 = ZW'(180) << ANG_FRAC;

  localparam logic [DEG_W-1:0] DEG_LIM = DEG_W'(90);
  localparam logic [BW-1:0]    BEAR_90  = BW'(90);
  localparam logic [BW-1:0]    BEAR_450 = BW'(450);
  localparam logic [BW-1:0]    BEAR_360 = BW'(360);

  // atan(2^-i) in degrees, Q.20, rounded
  localparam logic [AW-1:0] ATAN_DEG_Q20 [TABLE_LEN] = '{
    28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121,
    28'd3750058,  28'd1876857,  28'd938658,   28'd469357,
    28'd234682,   28'd117342,   28'd58671,    28'd29335,
    28'd14668,    28'd7334,     28'd3667,     28'd1833,
    28'd917,      28'd458,      28'd229,      28'd115,
    28'd57,       28'd29,       28'd14,       28'd7,
    28'd4,        28'd2,        28'd1,        28'd0,
    28'd0,        28'd0,        28'd0,        28'd0
  };

  // facts about the request that ride along the pipeline
  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic ay_zero;
    logic ax_zero;
    logic ax_eq_ay;
    logic ay_lt_ax;
  } side_t;

endpackage

// ===== src/vector_bearing_degrees.sv =====
// vector_bearing_degrees: compass bearing between two points, whole degrees.
// Depends on vbd_pkg, vbd_front, vbd_cell and vbd_back.
//
// Usage:
//   A request is the point pair (from_x_i, from_y_i) -> (to_x_i, to_y_i).
//   It is taken at any rising edge with start high and busy low. busy is
//   tied low: the pipeline takes a new request in every cycle.
//   bearing_o is 0..359: atan2(from_y - to_y, to_x - from_x) in degrees,
//   truncated toward zero, plus 90, wrapped into range. Equal points give 90.
//   The result shows on bearing_o for one cycle with strobe_o high.
// Pipeline: one front register (differences, magnitudes, exact-angle tests),
//   one register per CORDIC cell, one output register (clamp and fold).
// Throughput: one request per cycle, set by the fully unrolled cell row.
// Results leave in request order. The receiver cannot stall; a strobe is
//   never repeated or held.
// Reset: rst_ni clears the valid bits of every stage, so no strobe follows
//   until a request has been taken after reset. The data registers are not reset.
module vector_bearing_degrees
  import vbd_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] from_x_i,
  input  logic [COORD_BITS-1:0] from_y_i,
  input  logic [COORD_BITS-1:0] to_x_i,
  input  logic [COORD_BITS-1:0] to_y_i,
  output logic                  strobe_o,
  output logic [BW-1:0]         bearing_o
);

  // x, y carry the magnitudes times 2^32 with room for the CORDIC gain
  localparam int XW  = COORD_BITS + XY_SCALE + XY_GUARD;
  localparam int LAT = CORDIC_STAGES + 2;

  logic          take;
  logic          v_w [CORDIC_STAGES+1];
  logic [XW-1:0] x_w [CORDIC_STAGES+1];
  logic [XW-1:0] y_w [CORDIC_STAGES+1];
  logic [ZW-1:0] z_w [CORDIC_STAGES+1];
  side_t         s_w [CORDIC_STAGES+1];

  assign busy = 1'b0;
  assign take = start & ~busy;

  vbd_front #(
    .COORD_BITS(COORD_BITS),
    .XW        (XW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .from_x_i(from_x_i),
    .from_y_i(from_y_i),
    .to_x_i  (to_x_i),
    .to_y_i  (to_y_i),
    .valid_o (v_w[0]),
    .x_o     (x_w[0]),
    .y_o     (y_w[0]),
    .side_o  (s_w[0])
  );

  assign z_w[0] = '0;

  // row of rotation cells, one per CORDIC iteration
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    vbd_cell #(
      .XW   (XW),
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_w[g]),
      .x_i    (x_w[g]),
      .y_i    (y_w[g]),
      .z_i    (z_w[g]),
      .side_i (s_w[g]),
      .valid_o(v_w[g+1]),
      .x_o    (x_w[g+1]),
      .y_o    (y_w[g+1]),
      .z_o    (z_w[g+1]),
      .side_o (s_w[g+1])
    );
  end

  // final x, y are not needed; only the angle and flags go on
  vbd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v_w[CORDIC_STAGES]),
    .z_i      (z_w[CORDIC_STAGES]),
    .side_i   (s_w[CORDIC_STAGES]),
    .strobe_o (strobe_o),
    .bearing_o(bearing_o)
  );

`ifndef SYNTHESIS
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (bearing_o < BEAR_360))
    else $error("bearing out of range");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LAT strobe_o)
    else $error("request lost in pipeline");

  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(take, LAT))
    else $error("result without request");

  a_same_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && from_x_i == to_x_i && from_y_i == to_y_i) |->
      ##LAT (bearing_o == BEAR_90))
    else $error("equal points must give 90");
`endif

endmodule

// ===== src/vbd_front.sv =====
// vbd_front: difference, magnitude and exact-angle tests of a request.
// Depends on vbd_pkg.
module vbd_front
  import vbd_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int XW         = COORD_BITS + XY_SCALE + XY_GUARD
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] from_x_i,
  input  logic [COORD_BITS-1:0] from_y_i,
  input  logic [COORD_BITS-1:0] to_x_i,
  input  logic [COORD_BITS-1:0] to_y_i,
  output logic                  valid_o,
  output logic [XW-1:0]         x_o,
  output logic [XW-1:0]         y_o,
  output side_t                 side_o
);

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] ax, ay;
  side_t                 side_d, side_q;
  logic [XW-1:0]         x_d, y_d, x_q, y_q;
  logic                  valid_q;

  always_comb begin
    dx = {1'b0, to_x_i} - {1'b0, from_x_i};
    dy = {1'b0, from_y_i} - {1'b0, to_y_i};
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    side_d.dx_neg   = dx[COORD_BITS];
    side_d.dy_neg   = dy[COORD_BITS];
    side_d.ay_zero  = (ay == '0);
    side_d.ax_zero  = (ax == '0);
    side_d.ax_eq_ay = (ax == ay);
    side_d.ay_lt_ax = (ay < ax);
    x_d = {{XY_GUARD{1'b0}}, ax, {XY_SCALE{1'b0}}};
    y_d = {{XY_GUARD{1'b0}}, ay, {XY_SCALE{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

// ===== src/vbd_cell.sv =====
// vbd_cell: one CORDIC vectoring rotation by atan(2^-STAGE), registered.
// Depends on vbd_pkg.
module vbd_cell
  import vbd_pkg::*;
#(
  parameter int XW    = 51,
  parameter int STAGE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [XW-1:0] y_i,
  input  logic [ZW-1:0] z_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [XW-1:0] x_o,
  output logic [XW-1:0] y_o,
  output logic [ZW-1:0] z_o,
  output side_t         side_o
);

  localparam logic [ZW-1:0] ENTRY = {1'b0, ATAN_DEG_Q20[STAGE]};

  logic [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic [ZW-1:0] z_d, z_q;
  side_t         side_q;
  logic          valid_q;

  always_comb begin
    xs = $signed(x_i) >>> STAGE;  // floor shift
    ys = $signed(y_i) >>> STAGE;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ENTRY;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ENTRY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// ===== src/vbd_back.sv =====
// vbd_back: octant clamp, exact angles, quadrant fold and bearing wrap.
// Depends on vbd_pkg.
module vbd_back
  import vbd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [ZW-1:0] z_i,
  input  side_t         side_i,
  output logic          strobe_o,
  output logic [BW-1:0] bearing_o
);

  logic [ZW-1:0]    lo, hi, zc, u;
  logic [DEG_W-1:0] deg;
  logic [BW-1:0]    bearing_d, bearing_q;
  logic             strobe_q;

  always_comb begin
    if (side_i.ay_lt_ax) begin
      lo = '0;
      hi = Z45 - ZW'(1);
    end else begin
      lo = Z45;
      hi = Z90 - ZW'(1);
    end
    if (side_i.ay_zero) begin
      zc = '0;
    end else if (side_i.ax_zero) begin
      zc = Z90;
    end else if (side_i.ax_eq_ay) begin
      zc = Z45;
    end else if ($signed(z_i) < $signed(lo)) begin
      zc = lo;
    end else if ($signed(z_i) > $signed(hi)) begin
      zc = hi;
    end else begin
      zc = z_i;
    end
    u   = side_i.dx_neg ? (Z180 - zc) : zc;
    deg = u[ANG_FRAC +: DEG_W];
    if (!side_i.dy_neg) begin
      bearing_d = BEAR_90 + BW'(deg);
    end else if (deg > DEG_LIM) begin
      bearing_d = BEAR_450 - BW'(deg);  // wraps through 360
    end else begin
      bearing_d = BEAR_90 - BW'(deg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
  end

  assign strobe_o  = strobe_q;
  assign bearing_o = bearing_q;

endmodule
